// ===== hw/rtl/upr_pkg.sv =====
// Shared types, constants and helper functions of the UDP packet reflector.
`timescale 1ns / 1ps
`default_nettype none
package upr_pkg;

  // Header buffering geometry
  localparam int HDR_LEN    = 45;
  localparam int DECIDE_POS = 44;
  localparam int MIN_LEN    = 42;

  typedef logic [5:0] pos_t;

  // Frame verdict codes
  localparam logic [1:0] V_PASS    = 2'd0;
  localparam logic [1:0] V_REFLECT = 2'd1;
  localparam logic [1:0] V_DROP    = 2'd2;
  localparam logic [1:0] V_UNDEC   = 2'd3;

  // Command kinds passed from front to back
  localparam logic [1:0] K_BYTE = 2'd0;  // one frame byte after the decision
  localparam logic [1:0] K_HDR  = 2'd1;  // replay of the buffered header
  localparam logic [1:0] K_MARK = 2'd2;  // drop marker

  // Configuration register indexes
  localparam logic REG_BLOCKED_PORT = 1'b0;
  localparam logic REG_DNS_PORT     = 1'b1;

  localparam logic [15:0] BLOCKED_PORT_RST = 16'd443;
  localparam logic [15:0] DNS_PORT_RST     = 16'd53;

  // Command queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  verdict;
    logic        last;
    pos_t        pos;
    logic [15:0] aux;   // byte for K_BYTE, new checksum for K_HDR
  } cmd_t;

  typedef struct packed {
    logic       en;
    pos_t       addr;
    logic [7:0] data;
  } hdr_wr_t;

  // Source byte of a reflected header: MACs, IPs and ports swapped
  function automatic pos_t hdr_map(input pos_t i);
    pos_t r;
    if (i < 6'd6)                       r = i + 6'd6;
    else if (i < 6'd12)                 r = i - 6'd6;
    else if (i >= 6'd26 && i < 6'd30)   r = i + 6'd4;
    else if (i >= 6'd30 && i < 6'd34)   r = i - 6'd4;
    else if (i == 6'd34 || i == 6'd35)  r = i + 6'd2;
    else if (i == 6'd36 || i == 6'd37)  r = i - 6'd2;
    else                                r = i;
    return r;
  endfunction

  // 10/8, 127/8, 172.16/12, 192.168/16
  function automatic logic is_private(input logic [7:0] a, input logic [7:0] b);
    return (a == 8'd10) || (a == 8'd127) || ((a == 8'd172) && (b[7:4] == 4'h1)) ||
           ((a == 8'd192) && (b == 8'd168));
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/upr_stream_if.sv =====
// Valid/ready stream interfaces for the reflector's input and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface upr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;
  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface upr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        frame_end;
  logic [1:0]  verdict;
  logic [63:0] reflect_total;
  modport source (output valid, output out_byte, output run_last, output frame_end,
                  output verdict, output reflect_total, input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  input verdict, input reflect_total, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/udp_packet_reflector_core.sv =====
// UDP packet reflector: top level joining front end, command queue and back end.
//
// The block takes an Ethernet frame one byte per request on in_s (frame_last on the
// final byte) and returns result requests on out_s. The first 45 bytes are buffered;
// the frame is decided at byte 44 or at its last byte, then the buffered header is
// replayed, rewritten if reflected, and later bytes follow one result per byte.
// A dropped frame yields a single marker at its last byte.
// A passed-on byte goes through the command queue, the read stage and the output
// register before its result is valid.
// Throughput: one byte per cycle on both sides while the queue is not full, no header
// replay is pending and the receiver is ready; the back end replays up to 45 header
// bytes from one read port of the header buffer. The first byte of the next frame
// waits until that replay has read the buffer completely.
// cfg_we writes blocked_port (index 0) or dns_port (index 1).
// Reset (rst_n low, synchronous) empties the queue, clears the reflect counter and
// restores the port registers to 443 and 53. When the result receiver stalls, the
// output register and read stage hold, the 4-entry queue fills and in_s.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module udp_packet_reflector_core (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cfg_we,
  input  wire logic    cfg_index,
  input  wire logic [15:0] cfg_data,
  upr_in_if.sink       in_s,
  upr_out_if.source    out_s
);
  import upr_pkg::*;

  cmd_t    push_cmd, pop_cmd;
  hdr_wr_t hdr_wr;
  logic    push_en, pop_en, q_full, q_empty, run_done;

  upr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_s.valid),
    .in_data_byte  (in_s.data_byte),
    .in_frame_last (in_s.frame_last),
    .in_ready      (in_s.ready),
    .q_full        (q_full),
    .push_en       (push_en),
    .push_cmd      (push_cmd),
    .run_done      (run_done),
    .hdr_wr        (hdr_wr)
  );

  upr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (push_en),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop_en   (pop_en),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  upr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .hdr_wr            (hdr_wr),
    .pop_cmd           (pop_cmd),
    .q_empty           (q_empty),
    .pop_en            (pop_en),
    .run_done          (run_done),
    .out_valid         (out_s.valid),
    .out_ready         (out_s.ready),
    .out_byte          (out_s.out_byte),
    .out_run_last      (out_s.run_last),
    .out_frame_end     (out_s.frame_end),
    .out_verdict       (out_s.verdict),
    .out_reflect_total (out_s.reflect_total)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/upr_front.sv =====
// Front end: accepts frame bytes, captures header fields, decides the frame, issues commands.
`timescale 1ns / 1ps
`default_nettype none
module upr_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [15:0]    cfg_data,
  input  wire logic           in_valid,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic           in_frame_last,
  output logic                in_ready,
  input  wire logic           q_full,
  output logic                push_en,
  output upr_pkg::cmd_t       push_cmd,
  input  wire logic           run_done,
  output upr_pkg::hdr_wr_t    hdr_wr
);
  import upr_pkg::*;

  logic [15:0] blocked_r, dns_r;
  pos_t        pos_r, pos_nxt;
  logic [1:0]  verdict_r, verdict_nxt;
  logic        hdr_pend_r, hdr_pend_nxt;

  // Captured header fields
  logic [15:0] etype_r, frag_r, csum_r, sport_r, dport_r;
  logic [7:0]  ttl_r, proto_r;
  logic [31:0] src_r, dst_r;

  logic        accept, undec, decide_now;
  logic [1:0]  v;
  logic [15:0] m, mn, new_csum;
  logic [17:0] s1;
  logic [16:0] s2;
  logic [15:0] s3;

  assign undec      = (verdict_r == V_UNDEC);
  assign in_ready   = !q_full && !(undec && hdr_pend_r);
  assign accept     = in_valid && in_ready;
  assign decide_now = undec && ((pos_r == pos_t'(DECIDE_POS)) || in_frame_last);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_r <= BLOCKED_PORT_RST;
      dns_r     <= DNS_PORT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCKED_PORT: blocked_r <= cfg_data;
        REG_DNS_PORT:     dns_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Field capture by byte offset
  always_ff @(posedge clk) begin
    if (accept && undec) begin
      case (pos_r)
        6'd12: etype_r[15:8]  <= in_data_byte;
        6'd13: etype_r[7:0]   <= in_data_byte;
        6'd20: frag_r[15:8]   <= in_data_byte;
        6'd21: frag_r[7:0]    <= in_data_byte;
        6'd22: ttl_r          <= in_data_byte;
        6'd23: proto_r        <= in_data_byte;
        6'd24: csum_r[15:8]   <= in_data_byte;
        6'd25: csum_r[7:0]    <= in_data_byte;
        6'd26: src_r[31:24]   <= in_data_byte;
        6'd27: src_r[23:16]   <= in_data_byte;
        6'd28: src_r[15:8]    <= in_data_byte;
        6'd29: src_r[7:0]     <= in_data_byte;
        6'd30: dst_r[31:24]   <= in_data_byte;
        6'd31: dst_r[23:16]   <= in_data_byte;
        6'd32: dst_r[15:8]    <= in_data_byte;
        6'd33: dst_r[7:0]     <= in_data_byte;
        6'd34: sport_r[15:8]  <= in_data_byte;
        6'd35: sport_r[7:0]   <= in_data_byte;
        6'd36: dport_r[15:8]  <= in_data_byte;
        6'd37: dport_r[7:0]   <= in_data_byte;
        default: ;
      endcase
    end
  end

  // Verdict; once the frame is long enough the current byte holds no checked field
  // except the DNS flags byte at the decision position.
  always_comb begin
    v = V_REFLECT;
    if (pos_r < pos_t'(MIN_LEN - 1))                         v = V_PASS;
    else if (etype_r != 16'h0800 || proto_r != 8'd17)        v = V_PASS;
    else if ((frag_r & 16'h1FFF) != 16'h0000)                v = V_DROP;
    else if (src_r == dst_r)                                 v = V_PASS;
    else if (is_private(src_r[31:24], src_r[23:16]) ||
             is_private(dst_r[31:24], dst_r[23:16]))         v = V_PASS;
    else if (dport_r == blocked_r)                           v = V_PASS;
    else if (sport_r == dns_r && pos_r == pos_t'(DECIDE_POS) &&
             in_data_byte[7])                                v = V_PASS;
    else if (ttl_r <= 8'd1)                                  v = V_DROP;
  end

  // Incremental checksum update on the TTL/protocol word
  always_comb begin
    m        = {ttl_r, proto_r};
    mn       = {ttl_r - 8'd1, proto_r};
    s1       = {2'b00, ~csum_r} + {2'b00, ~m} + {2'b00, mn};
    s2       = {1'b0, s1[15:0]} + {15'd0, s1[17:16]};
    s3       = s2[15:0] + {15'd0, s2[16]};
    new_csum = ~s3;
  end

  // Command generation and frame state
  always_comb begin
    pos_nxt      = pos_r;
    verdict_nxt  = verdict_r;
    hdr_pend_nxt = hdr_pend_r && !run_done;
    push_en      = 1'b0;
    push_cmd     = '{kind: K_BYTE, verdict: verdict_r, last: in_frame_last,
                     pos: pos_r, aux: {8'd0, in_data_byte}};
    hdr_wr       = '{en: 1'b0, addr: pos_r, data: in_data_byte};
    if (accept) begin
      if (undec) begin
        hdr_wr.en = 1'b1;
        if (decide_now) begin
          if (v == V_DROP) begin
            push_en       = in_frame_last;
            push_cmd.kind = K_MARK;
          end else begin
            push_en        = 1'b1;
            push_cmd.kind  = K_HDR;
            push_cmd.aux   = new_csum;
            hdr_pend_nxt   = 1'b1;
          end
          push_cmd.verdict = v;
          verdict_nxt      = v;
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end else begin
        if (verdict_r == V_DROP) begin
          push_en       = in_frame_last;
          push_cmd.kind = K_MARK;
        end else begin
          push_en = 1'b1;
        end
      end
      if (in_frame_last) begin
        pos_nxt     = '0;
        verdict_nxt = V_UNDEC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      verdict_r  <= V_UNDEC;
      hdr_pend_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      verdict_r  <= verdict_nxt;
      hdr_pend_r <= hdr_pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/upr_queue.sv =====
// Small command FIFO between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module upr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_en,
  input  upr_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop_en,
  output upr_pkg::cmd_t      pop_cmd,
  output logic               empty
);
  import upr_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QAW-1:0]    wp_r, rp_r;
  logic [QAW:0]      cnt_r;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_en) slot_r[wp_r] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_en) wp_r <= wp_r + QAW'(1);
      if (pop_en)  rp_r <= rp_r + QAW'(1);
      case ({push_en, pop_en})
        2'b10:   cnt_r <= cnt_r + (QAW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QAW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/upr_back.sv =====
// Back end: header buffer, header replay sequencer, reflect counter and output register.
`timescale 1ns / 1ps
`default_nettype none
module upr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  upr_pkg::hdr_wr_t    hdr_wr,
  input  upr_pkg::cmd_t       pop_cmd,
  input  wire logic           q_empty,
  output logic                pop_en,
  output logic                run_done,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_frame_end,
  output logic [1:0]          out_verdict,
  output logic [63:0]         out_reflect_total
);
  import upr_pkg::*;

  // Byte source select of the read stage
  localparam logic [1:0] SEL_DIRECT = 2'd0;
  localparam logic [1:0] SEL_MEM    = 2'd1;
  localparam logic [1:0] SEL_DEC    = 2'd2;

  logic [7:0]  hdr_mem [HDR_LEN];
  logic [7:0]  rd_data_r;
  logic        rd_en;
  pos_t        rd_addr;

  // Replay sequencer
  logic        run_act_r, run_act_nxt;
  pos_t        run_idx_r, run_idx_nxt, run_pos_r;
  logic [1:0]  run_verdict_r;
  logic        run_last_r;
  logic [15:0] run_csum_r;
  logic        run_start;

  logic [63:0] count_r, count_nxt;

  // Read stage
  logic        s1_valid_r, s1_valid_nxt, s1_load;
  logic [1:0]  s1_sel_r, s1_sel_nxt;
  logic [7:0]  s1_byte_r, s1_byte_nxt;
  logic        s1_rl_r, s1_rl_nxt, s1_fe_r, s1_fe_nxt;
  logic [1:0]  s1_verdict_r, s1_verdict_nxt;
  logic [63:0] s1_total_r;

  logic        out_valid_r, out_adv, s1_free, reflect, fin;
  logic [7:0]  s1_out_byte;

  // Header buffer: one write port from the front, one registered read port
  always_ff @(posedge clk) begin
    if (hdr_wr.en) hdr_mem[hdr_wr.addr] <= hdr_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= hdr_mem[rd_addr];
  end

  assign out_adv = !out_valid_r || out_ready;
  assign s1_free = !s1_valid_r || out_adv;
  assign reflect = (run_verdict_r == V_REFLECT);
  assign fin     = (run_idx_r == run_pos_r);

  // Sequencing: header replay first, otherwise take the next command
  always_comb begin
    rd_en          = 1'b0;
    rd_addr        = reflect ? hdr_map(run_idx_r) : run_idx_r;
    pop_en         = 1'b0;
    run_start      = 1'b0;
    run_done       = 1'b0;
    run_act_nxt    = run_act_r;
    run_idx_nxt    = run_idx_r;
    count_nxt      = count_r;
    s1_load        = 1'b0;
    s1_sel_nxt     = SEL_DIRECT;
    s1_byte_nxt    = pop_cmd.aux[7:0];
    s1_rl_nxt      = 1'b1;
    s1_fe_nxt      = pop_cmd.last;
    s1_verdict_nxt = pop_cmd.verdict;
    if (s1_free) begin
      if (run_act_r) begin
        s1_load        = 1'b1;
        rd_en          = 1'b1;
        s1_sel_nxt     = SEL_MEM;
        s1_rl_nxt      = fin;
        s1_fe_nxt      = fin && run_last_r;
        s1_verdict_nxt = run_verdict_r;
        if (reflect) begin
          if (run_idx_r == 6'd22) begin
            s1_sel_nxt = SEL_DEC;
          end else if (run_idx_r == 6'd24) begin
            s1_sel_nxt  = SEL_DIRECT;
            s1_byte_nxt = run_csum_r[15:8];
          end else if (run_idx_r == 6'd25) begin
            s1_sel_nxt  = SEL_DIRECT;
            s1_byte_nxt = run_csum_r[7:0];
          end
          if (run_idx_r == '0) count_nxt = count_r + 64'd1;
        end
        if (fin) begin
          run_act_nxt = 1'b0;
          run_done    = 1'b1;
        end else begin
          run_idx_nxt = run_idx_r + 6'd1;
        end
      end else if (!q_empty) begin
        pop_en = 1'b1;
        case (pop_cmd.kind)
          K_HDR: begin
            run_start   = 1'b1;
            run_act_nxt = 1'b1;
            run_idx_nxt = '0;
          end
          K_MARK: begin
            s1_load        = 1'b1;
            s1_byte_nxt    = 8'd0;
            s1_fe_nxt      = 1'b1;
            s1_verdict_nxt = V_DROP;
          end
          default: begin
            s1_load = 1'b1;
          end
        endcase
      end
    end
    s1_valid_nxt = s1_load ? 1'b1 : (out_adv ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_act_r   <= 1'b0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_act_r   <= run_act_nxt;
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    run_idx_r <= run_idx_nxt;
    if (run_start) begin
      run_pos_r     <= pop_cmd.pos;
      run_verdict_r <= pop_cmd.verdict;
      run_last_r    <= pop_cmd.last;
      run_csum_r    <= pop_cmd.aux;
    end
    if (s1_load) begin
      s1_sel_r     <= s1_sel_nxt;
      s1_byte_r    <= s1_byte_nxt;
      s1_rl_r      <= s1_rl_nxt;
      s1_fe_r      <= s1_fe_nxt;
      s1_verdict_r <= s1_verdict_nxt;
      s1_total_r   <= count_nxt;
    end
    if (out_adv && s1_valid_r) begin
      out_byte          <= s1_out_byte;
      out_run_last      <= s1_rl_r;
      out_frame_end     <= s1_fe_r;
      out_verdict       <= s1_verdict_r;
      out_reflect_total <= s1_total_r;
    end
  end

  // Byte selection after the buffer read
  always_comb begin
    case (s1_sel_r)
      SEL_MEM: s1_out_byte = rd_data_r;
      SEL_DEC: s1_out_byte = rd_data_r - 8'd1;
      default: s1_out_byte = s1_byte_r;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for udp_packet_reflector_core: frame stimulus, reflection predictor, result checks.
`timescale 1ns / 1ps
module tb;
  import upr_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 64;
  localparam int FRAME_MAX     = 64;
  localparam int PHASE_BYTES   = 20;

  // Fixed public endpoints for the directed frames
  localparam logic [31:0] DIR_SRC = 32'hC6336401;
  localparam logic [31:0] DIR_DST = 32'hCB007105;
  localparam logic [15:0] DIR_SP  = 16'hC001;
  localparam logic [15:0] DIR_DP  = 16'h1F90;

  typedef struct packed {
    logic [7:0]  data;
    logic        run_last;
    logic        frame_end;
    logic [1:0]  verdict;
    logic [63:0] total;
  } result_t;

  // Predicts the reflector's output bytes and checks them in order
  class reflector_scoreboard;
    logic [7:0]  hdr [HDR_LEN];
    int          fill;
    logic [1:0]  frame_v;
    logic [63:0] reflected;
    logic [15:0] blocked_port;
    logic [15:0] dns_port;
    result_t     expected_bytes [$];
    int          mismatches;

    function new();
      foreach (hdr[i]) hdr[i] = 8'h00;
      fill         = 0;
      frame_v      = V_UNDEC;
      reflected    = '0;
      blocked_port = BLOCKED_PORT_RST;
      dns_port     = DNS_PORT_RST;
      mismatches   = 0;
    endfunction

    function void set_port(logic idx, logic [15:0] val);
      if (idx == REG_BLOCKED_PORT) blocked_port = val;
      else dns_port = val;
    endfunction

    function logic [15:0] word_at(int i);
      return {hdr[i], hdr[i + 1]};
    endfunction

    function bit private_at(int i);
      return hdr[i] == 8'd10 || hdr[i] == 8'd127 ||
             (hdr[i] == 8'd172 && hdr[i + 1][7:4] == 4'h1) ||
             (hdr[i] == 8'd192 && hdr[i + 1] == 8'd168);
    endfunction

    function void push(logic [7:0] d, logic rl, logic fe, logic [1:0] v);
      result_t r;
      r.data      = d;
      r.run_last  = rl;
      r.frame_end = fe;
      r.verdict   = v;
      r.total     = reflected;
      expected_bytes.push_back(r);
    endfunction

    // One accepted frame byte
    function void take_request(logic [7:0] b, logic last);
      int         p;
      int         i;
      logic [1:0] v;
      logic [7:0] ttl_m1;
      logic [7:0] d;
      logic [31:0] s;
      logic [15:0] csum;
      // frame already decided: pass bytes through or swallow them
      if (frame_v != V_UNDEC) begin
        if (frame_v != V_DROP) push(b, 1'b1, last, frame_v);
        else if (last) push(8'h00, 1'b1, 1'b1, V_DROP);
        if (last) begin
          fill    = 0;
          frame_v = V_UNDEC;
        end
        return;
      end
      p      = fill;
      hdr[p] = b;
      if (p < DECIDE_POS && !last) begin
        fill = p + 1;
        return;
      end
      // decision, first matching rule wins
      if (p + 1 < MIN_LEN) v = V_PASS;
      else if (word_at(12) != 16'h0800 || hdr[23] != 8'd17) v = V_PASS;
      else if ((word_at(20) & 16'h1FFF) != 16'h0000) v = V_DROP;
      else if ({hdr[26], hdr[27], hdr[28], hdr[29]} == {hdr[30], hdr[31], hdr[32], hdr[33]})
        v = V_PASS;
      else if (private_at(26) || private_at(30)) v = V_PASS;
      else if (word_at(36) == blocked_port) v = V_PASS;
      else if (word_at(34) == dns_port && p == DECIDE_POS && hdr[DECIDE_POS][7]) v = V_PASS;
      else if (hdr[22] <= 8'd1) v = V_DROP;
      else v = V_REFLECT;
      if (v == V_REFLECT) reflected++;
      // ones-complement checksum patch for the TTL decrement
      ttl_m1 = hdr[22] - 8'd1;
      s = {16'h0, ~word_at(24)} + {16'h0, ~{hdr[22], hdr[23]}} + {16'h0, ttl_m1, hdr[23]};
      s = (s & 32'hFFFF) + (s >> 16);
      s = (s & 32'hFFFF) + (s >> 16);
      csum = ~s[15:0];
      if (v == V_DROP) begin
        if (last) push(8'h00, 1'b1, 1'b1, V_DROP);
      end else begin
        for (i = 0; i <= p; i++) begin
          d = hdr[i];
          if (v == V_REFLECT) begin
            if (i < 6) d = hdr[i + 6];
            else if (i < 12) d = hdr[i - 6];
            else if (i == 22) d = ttl_m1;
            else if (i == 24) d = csum[15:8];
            else if (i == 25) d = csum[7:0];
            else if (i >= 26 && i < 30) d = hdr[i + 4];
            else if (i >= 30 && i < 34) d = hdr[i - 4];
            else if (i == 34 || i == 35) d = hdr[i + 2];
            else if (i == 36 || i == 37) d = hdr[i - 2];
          end
          push(d, i == p, (i == p) && last, v);
        end
      end
      if (last) begin
        fill    = 0;
        frame_v = V_UNDEC;
      end else begin
        frame_v = v;
        fill    = p;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result byte %h run_last %b frame_end %b verdict %0d total %0d",
                   got.data, got.run_last, got.frame_end, got.verdict, got.total);
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch exp %h/%b/%b/%0d/%0d got %h/%b/%b/%0d/%0d",
                   want.data, want.run_last, want.frame_end, want.verdict, want.total,
                   got.data, got.run_last, got.frame_end, got.verdict, got.total);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  upr_in_if  in_if ();
  upr_out_if out_if ();

  udp_packet_reflector_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_s      (in_if),
    .out_s     (out_if)
  );

  reflector_scoreboard sb;
  int          burst_left;
  int          bytes_sent;
  int          idle_cycles;
  int          pattern_age;
  logic [15:0] ready_pattern;
  result_t     seen;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Sender: bursts of requests separated by random gaps
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4))
        @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.frame_last <= last;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    bytes_sent++;
    sb.take_request(b, last);
  endtask

  task automatic send_noise(input int len);
    int i;
    for (i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
  endtask

  // Ethernet + IPv4 + UDP frame, random where not given, cut to len bytes
  task automatic send_udp_frame(input logic [15:0] et, input logic [7:0] pr,
                                input logic [15:0] frag, input logic [7:0] ttl,
                                input logic [31:0] sa, input logic [31:0] da,
                                input logic [15:0] sp, input logic [15:0] dp,
                                input logic [7:0] fl, input int len);
    logic [7:0] f [FRAME_MAX];
    int i;
    foreach (f[k]) f[k] = 8'($urandom);
    {f[12], f[13]} = et;
    f[14] = 8'h45;
    {f[20], f[21]} = frag;
    f[22] = ttl;
    f[23] = pr;
    {f[26], f[27], f[28], f[29]} = sa;
    {f[30], f[31], f[32], f[33]} = da;
    {f[34], f[35]} = sp;
    {f[36], f[37]} = dp;
    f[44] = fl;
    for (i = 0; i < len; i++) send_byte(f[i], i == len - 1);
  endtask

  function automatic logic [31:0] public_addr();
    logic [7:0] a;
    logic [7:0] b;
    b = 8'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        a = 8'd172;
        b = 8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(32, 255));
      end
      1: begin
        a = 8'd192;
        if (b == 8'd168) b = 8'd169;
      end
      default: begin
        a = 8'($urandom_range(1, 254));
        if (a == 8'd10 || a == 8'd127 || a == 8'd172 || a == 8'd192) a = a + 8'd1;
      end
    endcase
    return {a, b, 16'($urandom)};
  endfunction

  function automatic logic [31:0] private_addr();
    case ($urandom_range(0, 3))
      0:       return {8'd10, 24'($urandom)};
      1:       return {8'd127, 24'($urandom)};
      2:       return {8'd172, 4'h1, 20'($urandom)};
      default: return {8'd192, 8'd168, 16'($urandom)};
    endcase
  endfunction

  // Mostly well-formed UDP with at most one rule-triggering tweak; some noise and cut frames
  task automatic send_random_frame();
    logic [15:0] et, frag, sp, dp;
    logic [7:0]  pr, ttl, fl;
    logic [31:0] sa, da;
    int          len;
    int          kind;
    et   = 16'h0800;
    pr   = 8'd17;
    frag = 16'($urandom_range(0, 7) << 13);
    ttl  = 8'($urandom_range(2, 255));
    sa   = public_addr();
    da   = public_addr();
    sp   = 16'($urandom);
    dp   = 16'($urandom);
    fl   = 8'($urandom);
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(53, FRAME_MAX) : $urandom_range(42, 52);
    kind = $urandom_range(0, 19);
    case (kind)
      1: len = $urandom_range(1, 44);
      2: et = 16'($urandom);
      3: pr = 8'($urandom);
      4: frag[12:0] = 13'($urandom_range(1, 8191));
      5: da = sa;
      6: if ($urandom_range(0, 1)) sa = private_addr(); else da = private_addr();
      7: dp = sb.blocked_port;
      8: sp = sb.dns_port;
      9: ttl = 8'($urandom_range(0, 2));
      default: ;
    endcase
    if (kind == 0) send_noise($urandom_range(1, 50));
    else send_udp_frame(et, pr, frag, ttl, sa, da, sp, dp, fl, len);
  endtask

  task automatic random_phase(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_frame();
  endtask

  // Drop valid, wait for every expected byte, then let the back end drain
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ports(input logic [15:0] blocked, input logic [15:0] dns);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLOCKED_PORT;
    cfg_data  <= blocked;
    @(negedge clk);
    cfg_index <= REG_DNS_PORT;
    cfg_data  <= dns;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_port(REG_BLOCKED_PORT, blocked);
    sb.set_port(REG_DNS_PORT, dns);
  endtask

  // Receiver back-pressure from a rotating pattern, reshuffled now and then
  initial begin
    out_if.ready  = 1'b0;
    ready_pattern = 16'hFFFF;
    pattern_age   = 0;
    forever begin
      @(negedge clk);
      if (pattern_age == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    ready_pattern = 16'hFFFF;
          2:       ready_pattern = 16'($urandom) | 16'h0001;
          3:       ready_pattern = 16'($urandom & $urandom) | 16'h0001;
          default: ready_pattern = 16'h8000;
        endcase
      end
      pattern_age   = (pattern_age + 1) % 48;
      out_if.ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.data      = out_if.out_byte;
      seen.run_last  = out_if.run_last;
      seen.frame_end = out_if.frame_end;
      seen.verdict   = out_if.verdict;
      seen.total     = out_if.reflect_total;
      sb.check_result(seen);
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    sb               = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_BLOCKED_PORT;
    cfg_data         = 16'h0000;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.frame_last = 1'b0;
    burst_left       = 0;
    bytes_sent       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one-byte frames at both byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // just under the minimum length, then a reflect decided at the flags byte
    send_udp_frame(16'h0800, 8'd17, 16'h4000, 8'd64, DIR_SRC, DIR_DST, DIR_SP, DIR_DP, 8'h00, 41);
    send_udp_frame(16'h0800, 8'd17, 16'h0000, 8'd64, DIR_SRC, DIR_DST, DIR_SP, DIR_DP, 8'h00, 45);
    // fragment is dropped, marker at the end
    send_udp_frame(16'h0800, 8'd17, 16'h1FFF, 8'd64, DIR_SRC, DIR_DST, DIR_SP, DIR_DP, 8'h00, 48);
    // DNS response with the QR bit set
    send_udp_frame(16'h0800, 8'd17, 16'h0000, 8'd64, DIR_SRC, DIR_DST, 16'd53, DIR_DP, 8'h80, 45);
    // TTL expiry, and the TTL extreme that still reflects with bytes after the decision
    send_udp_frame(16'h0800, 8'd17, 16'h0000, 8'd1, DIR_SRC, DIR_DST, DIR_SP, DIR_DP, 8'h00, 42);
    send_udp_frame(16'h0800, 8'd17, 16'h0000, 8'd255, DIR_SRC, DIR_DST, 16'h0000, 16'hFFFF,
                   8'h00, 46);

    // random traffic under several port settings
    random_phase(PHASE_BYTES);
    write_ports(16'h0000, 16'hFFFF);
    random_phase(PHASE_BYTES);
    write_ports(16'hFFFF, 16'h0000);
    random_phase(PHASE_BYTES);
    write_ports(16'($urandom), 16'($urandom));
    random_phase(PHASE_BYTES);

    settle();
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
